// ===== hdl/stsg_pkg.sv =====
// ---------------------------------------------------------------------------
// Scaled tanh / SiLU gate cell package
// Item types, fixed-point constants and the exponential table shared by the
// cell and its testbench.
// ---------------------------------------------------------------------------
package stsg_pkg;

   typedef struct packed {
      logic signed [15:0] input_term;
      logic signed [15:0] recurrent_term;
      logic signed [15:0] radius;
      logic signed [15:0] bias;
      logic signed [15:0] gate_in;
   } req_type;

   typedef struct packed {
      logic signed [13:0] hidden;
      logic signed [15:0] gated;
      logic signed [15:0] pre_activation;
   } rsp_type;

   localparam int EXP_BITS  = 16;
   localparam int QUO_BITS  = 25;
   localparam int REM_W     = 52;
   localparam int DIV_W     = 27;

   // Cycles from the accepting edge until the result is on the ports.
   localparam int PIPE_LATENCY = 50;

   localparam logic [24:0] Q24_ONE  = 25'd16777216;
   localparam logic [12:0] HID_ONE  = 13'd4096;
   localparam logic [16:0] TANH_SAT = 17'd20480;

   // e^-(2^(k-12)) in unsigned Q0.24.
   localparam logic [23:0] EXP_TAB [EXP_BITS] = '{
      24'd16773120, 24'd16769026, 24'd16760840, 24'd16744480,
      24'd16711808, 24'd16646655, 24'd16517109, 24'd16261035,
      24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
      24'd6171993,  24'd2270549,  24'd307285,   24'd5628
   };

endpackage

// ===== hdl/scaled_tanh_silu_gate_cell.sv =====
// ---------------------------------------------------------------------------
// Scaled tanh cell with SiLU gate
// Computes pre = x + radius*r + bias, hidden = tanh(pre) and
// gated = hidden * silu(gate) in signed Q3.12, fully pipelined.
// ---------------------------------------------------------------------------
// The cell takes one item in every cycle and busy is always low. Each result
// appears on the rsp ports for one cycle, marked by rsp_strobe. The pipeline
// holds the sixteen multiply stages of the two exponential chains and the
// twenty-five one-bit stages of the two restoring dividers; the receiver
// cannot stall, so nothing waits.
module scaled_tanh_silu_gate_cell
   import stsg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   typedef struct packed {
      logic signed [15:0] pre;
      logic signed [15:0] gate;
      logic               tsat;
      logic [15:0]        yt;
      logic [15:0]        yg;
      logic [24:0]        et;
      logic [24:0]        eg;
   } exp_type;

   typedef struct packed {
      logic signed [15:0]  pre;
      logic signed [15:0]  gate;
      logic                tsat;
      logic [REM_W-1:0]    tn;
      logic [DIV_W-1:0]    td;
      logic [QUO_BITS-1:0] tq;
      logic [REM_W-1:0]    sn;
      logic [DIV_W-1:0]    sd;
      logic [QUO_BITS-1:0] sq;
   } div_type;

   assign busy = 1'b0;

   // Input register.
   req_type a_ff;
   logic    a_v_ff;

   // Radius product.
   logic signed [31:0] b_prod_in, b_prod_ff;
   logic signed [15:0] b_x_ff, b_b_ff, b_g_ff;
   logic               b_v_ff;

   // Rounded scaled term.
   logic [31:0]        c_mag;
   logic [31:0]        c_rsum;
   logic signed [19:0] c_scaled_in, c_scaled_ff;
   logic signed [15:0] c_x_ff, c_b_ff, c_g_ff;
   logic               c_v_ff;

   // Saturated pre-activation.
   logic signed [20:0] d_sum;
   logic signed [15:0] d_pre_in, d_pre_ff, d_g_ff;
   logic               d_v_ff;

   // Exponential chains.
   logic [16:0]       e_a;
   logic [16:0]       e_ag;
   exp_type           ex_in  [EXP_BITS+1];
   exp_type           ex_ff  [EXP_BITS+1];
   logic [EXP_BITS:0] ex_v_ff;

   // Dividers.
   logic [25:0]       s_den, t_den;
   div_type           dv_in  [QUO_BITS+1];
   div_type           dv_ff  [QUO_BITS+1];
   logic [QUO_BITS:0] dv_v_ff;

   // Output arithmetic.
   logic [12:0]        h_mag;
   logic signed [13:0] h_in, h_ff, g_h_ff;
   logic [24:0]        h_s_ff, g_s_ff;
   logic signed [15:0] h_pre_ff, h_g_ff, g_pre_ff, p_pre_ff;
   logic               h_v_ff, g_v_ff, p_v_ff;
   logic signed [29:0] g_hg_in, g_hg_ff;
   logic signed [55:0] p_prod_in, p_prod_ff;
   logic signed [13:0] p_h_ff;
   logic [55:0]        o_mag;
   logic [55:0]        o_rsum;
   logic signed [20:0] o_val;
   logic signed [15:0] o_sat;
   rsp_type            o_in, o_ff;
   logic               o_v_ff;

   always_ff @(posedge clock) begin
      a_ff <= req_item;
      if (reset) begin
         a_v_ff <= 1'b0;
      end else begin
         a_v_ff <= start & ~busy;
      end
   end

   assign b_prod_in = a_ff.recurrent_term * a_ff.radius;

   always_ff @(posedge clock) begin
      b_prod_ff <= b_prod_in;
      b_x_ff    <= a_ff.input_term;
      b_b_ff    <= a_ff.bias;
      b_g_ff    <= a_ff.gate_in;
      if (reset) begin
         b_v_ff <= 1'b0;
      end else begin
         b_v_ff <= a_v_ff;
      end
   end

   always_comb begin
      c_mag  = b_prod_ff[31] ? 32'(-b_prod_ff) : 32'(b_prod_ff);
      c_rsum = c_mag + 32'd2048;
      if (b_prod_ff[31]) begin
         c_scaled_in = -$signed({1'b0, c_rsum[30:12]});
      end else begin
         c_scaled_in = $signed({1'b0, c_rsum[30:12]});
      end
   end

   always_ff @(posedge clock) begin
      c_scaled_ff <= c_scaled_in;
      c_x_ff      <= b_x_ff;
      c_b_ff      <= b_b_ff;
      c_g_ff      <= b_g_ff;
      if (reset) begin
         c_v_ff <= 1'b0;
      end else begin
         c_v_ff <= b_v_ff;
      end
   end

   always_comb begin
      d_sum = 21'(c_x_ff) + 21'(c_scaled_ff) + 21'(c_b_ff);
      if (d_sum > 21'sd32767) begin
         d_pre_in = 16'sh7FFF;
      end else if (d_sum < -21'sd32768) begin
         d_pre_in = 16'sh8000;
      end else begin
         d_pre_in = d_sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      d_pre_ff <= d_pre_in;
      d_g_ff   <= c_g_ff;
      if (reset) begin
         d_v_ff <= 1'b0;
      end else begin
         d_v_ff <= c_v_ff;
      end
   end

   always_comb begin
      e_a  = d_pre_ff[15] ? 17'(-17'(d_pre_ff)) : 17'(d_pre_ff);
      e_ag = d_g_ff[15] ? 17'(-17'(d_g_ff)) : 17'(d_g_ff);
      ex_in[0].pre  = d_pre_ff;
      ex_in[0].gate = d_g_ff;
      ex_in[0].tsat = (e_a >= TANH_SAT);
      ex_in[0].yt   = {e_a[14:0], 1'b0};
      ex_in[0].yg   = e_ag[15:0];
      ex_in[0].et   = Q24_ONE;
      ex_in[0].eg   = Q24_ONE;
   end

   for (genvar k = 0; k < EXP_BITS; k++) begin : g_exp
      logic [48:0] pt, pg;
      always_comb begin
         pt = ex_ff[k].et * EXP_TAB[k] + 49'd8388608;
         pg = ex_ff[k].eg * EXP_TAB[k] + 49'd8388608;
         ex_in[k+1]    = ex_ff[k];
         if (ex_ff[k].yt[k]) begin
            ex_in[k+1].et = pt[48:24];
         end
         if (ex_ff[k].yg[k]) begin
            ex_in[k+1].eg = pg[48:24];
         end
      end
   end

   for (genvar k = 0; k <= EXP_BITS; k++) begin : g_exp_reg
      always_ff @(posedge clock) begin
         ex_ff[k] <= ex_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_v_ff <= '0;
      end else begin
         ex_v_ff <= {ex_v_ff[EXP_BITS-1:0], d_v_ff};
      end
   end

   always_comb begin
      t_den = 26'(Q24_ONE) + 26'(ex_ff[EXP_BITS].et);
      s_den = 26'(Q24_ONE) + 26'(ex_ff[EXP_BITS].eg);
      dv_in[0].pre  = ex_ff[EXP_BITS].pre;
      dv_in[0].gate = ex_ff[EXP_BITS].gate;
      dv_in[0].tsat = ex_ff[EXP_BITS].tsat;
      dv_in[0].tn   = (REM_W'(Q24_ONE - ex_ff[EXP_BITS].et) << 13) + REM_W'(t_den);
      dv_in[0].td   = {t_den, 1'b0};
      dv_in[0].tq   = '0;
      if (ex_ff[EXP_BITS].gate[15]) begin
         dv_in[0].sn = (REM_W'(ex_ff[EXP_BITS].eg) << 24) + REM_W'(s_den[25:1]);
      end else begin
         dv_in[0].sn = (REM_W'(1) << 48) + REM_W'(s_den[25:1]);
      end
      dv_in[0].sd   = DIV_W'(s_den);
      dv_in[0].sq   = '0;
   end

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      localparam int B = QUO_BITS - 1 - j;
      logic [REM_W-1:0] tsh, ssh;
      always_comb begin
         tsh = REM_W'(dv_ff[j].td) << B;
         ssh = REM_W'(dv_ff[j].sd) << B;
         dv_in[j+1] = dv_ff[j];
         if (dv_ff[j].tn >= tsh) begin
            dv_in[j+1].tn    = dv_ff[j].tn - tsh;
            dv_in[j+1].tq[B] = 1'b1;
         end
         if (dv_ff[j].sn >= ssh) begin
            dv_in[j+1].sn    = dv_ff[j].sn - ssh;
            dv_in[j+1].sq[B] = 1'b1;
         end
      end
   end

   for (genvar j = 0; j <= QUO_BITS; j++) begin : g_div_reg
      always_ff @(posedge clock) begin
         dv_ff[j] <= dv_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff <= '0;
      end else begin
         dv_v_ff <= {dv_v_ff[QUO_BITS-1:0], ex_v_ff[EXP_BITS]};
      end
   end

   always_comb begin
      h_mag = dv_ff[QUO_BITS].tsat ? HID_ONE : dv_ff[QUO_BITS].tq[12:0];
      if (dv_ff[QUO_BITS].pre[15]) begin
         h_in = -$signed({1'b0, h_mag});
      end else begin
         h_in = $signed({1'b0, h_mag});
      end
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      h_s_ff   <= dv_ff[QUO_BITS].sq;
      h_pre_ff <= dv_ff[QUO_BITS].pre;
      h_g_ff   <= dv_ff[QUO_BITS].gate;
      if (reset) begin
         h_v_ff <= 1'b0;
      end else begin
         h_v_ff <= dv_v_ff[QUO_BITS];
      end
   end

   assign g_hg_in = h_ff * h_g_ff;

   always_ff @(posedge clock) begin
      g_hg_ff  <= g_hg_in;
      g_s_ff   <= h_s_ff;
      g_h_ff   <= h_ff;
      g_pre_ff <= h_pre_ff;
      if (reset) begin
         g_v_ff <= 1'b0;
      end else begin
         g_v_ff <= h_v_ff;
      end
   end

   assign p_prod_in = 56'(g_hg_ff) * 56'($signed({1'b0, g_s_ff}));

   always_ff @(posedge clock) begin
      p_prod_ff <= p_prod_in;
      p_h_ff    <= g_h_ff;
      p_pre_ff  <= g_pre_ff;
      if (reset) begin
         p_v_ff <= 1'b0;
      end else begin
         p_v_ff <= g_v_ff;
      end
   end

   always_comb begin
      o_mag  = p_prod_ff[55] ? 56'(-p_prod_ff) : 56'(p_prod_ff);
      o_rsum = o_mag + (56'(1) << 35);
      if (p_prod_ff[55]) begin
         o_val = -$signed({1'b0, o_rsum[55:36]});
      end else begin
         o_val = $signed({1'b0, o_rsum[55:36]});
      end
      if (o_val > 21'sd32767) begin
         o_sat = 16'sh7FFF;
      end else if (o_val < -21'sd32768) begin
         o_sat = 16'sh8000;
      end else begin
         o_sat = o_val[15:0];
      end
      o_in.hidden         = p_h_ff;
      o_in.gated          = o_sat;
      o_in.pre_activation = p_pre_ff;
   end

   always_ff @(posedge clock) begin
      o_ff <= o_in;
      if (reset) begin
         o_v_ff <= 1'b0;
      end else begin
         o_v_ff <= p_v_ff;
      end
   end

   assign rsp_strobe = o_v_ff;
   assign rsp_item   = o_ff;

endmodule

// ===== hdl/stsg_checker.sv =====
// ---------------------------------------------------------------------------
// Scaled tanh / SiLU gate cell checker
// Port-level properties of the cell, bound into the cell module.
// ---------------------------------------------------------------------------
module stsg_checker
   import stsg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised although the cell never stalls");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LATENCY + 1))
      else $error("result without an item accepted at the pipeline latency");

   a_hidden_sign : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.pre_activation[15] ? (rsp_item.hidden <= 14'sd0)
                                                  : (rsp_item.hidden >= 14'sd0)))
      else $error("hidden sign disagrees with the pre-activation");

   a_gate_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.hidden == 14'sd0) |-> (rsp_item.gated == 16'sd0))
      else $error("gated output nonzero for a zero hidden value");

   a_hidden_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.hidden <= 14'sd4096 && rsp_item.hidden >= -14'sd4096))
      else $error("hidden value outside minus one to one");

endmodule

bind scaled_tanh_silu_gate_cell stsg_checker u_stsg_checker (.*);

// ===== tb/tb_scaled_tanh_silu_gate_cell.sv =====
// ---------------------------------------------------------------------------
// Scaled tanh / SiLU gate cell testbench
// Drives directed corner items and then random items with random gaps,
// predicts hidden, gated and pre-activation per item in fixed point, and
// compares each strobed result in order against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scaled_tanh_silu_gate_cell
   import stsg_pkg::*;
();

   class cell_scoreboard;
      rsp_type pending[$];
      int errors = 0;

      function longint round_shift(longint v, int s);
         longint m;
         m = (v < 0) ? -v : v;
         m = (m + (longint'(1) << (s - 1))) >>> s;
         return (v < 0) ? -m : m;
      endfunction

      function longint clip16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint exp_neg(int unsigned y);
         longint e;
         e = 64'd16777216;
         for (int k = 0; k < EXP_BITS; k++)
            if (y[k]) e = (e * longint'(EXP_TAB[k]) + 64'd8388608) >>> 24;
         return e;
      endfunction

      function longint tanh_fix(longint x);
         longint a, e, den, mag;
         a = (x < 0) ? -x : x;
         if (a >= 20480) begin
            mag = 4096;
         end else begin
            e = exp_neg(int'(2 * a));
            den = 64'd16777216 + e;
            mag = ((64'd16777216 - e) * 8192 + den) / (2 * den);
         end
         return (x < 0) ? -mag : mag;
      endfunction

      function longint sigmoid_fix(longint g);
         longint a, e, den, num;
         a = (g < 0) ? -g : g;
         e = exp_neg(int'(a & 16'hFFFF));
         den = 64'd16777216 + e;
         num = (g < 0) ? (e << 24) : (longint'(1) << 48);
         return (num + den / 2) / den;
      endfunction

      function void note_item(req_type it);
         longint x, r, rad, b, g, pre, h, s, q;
         logic signed [127:0] prod, m;
         rsp_type exp_r;
         x = it.input_term; r = it.recurrent_term; rad = it.radius;
         b = it.bias; g = it.gate_in;
         pre = clip16(x + round_shift(r * rad, 12) + b);
         h = tanh_fix(pre);
         s = sigmoid_fix(g);
         prod = 128'(h * g) * 128'(s);
         m = (prod < 0) ? -prod : prod;
         m = (m + (128'sd1 <<< 35)) >>> 36;
         q = longint'(m);
         if (prod < 0) q = -q;
         exp_r.hidden = h[13:0];
         exp_r.gated = 16'(clip16(q));
         exp_r.pre_activation = pre[15:0];
         pending.push_back(exp_r);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.hidden !== e.hidden) begin
            $display("%0t: hidden expected %0d actual %0d", $time, e.hidden, got.hidden);
            errors++;
         end
         if (got.gated !== e.gated) begin
            $display("%0t: gated expected %0d actual %0d", $time, e.gated, got.gated);
            errors++;
         end
         if (got.pre_activation !== e.pre_activation) begin
            $display("%0t: pre_activation expected %0d actual %0d", $time,
                     e.pre_activation, got.pre_activation);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   cell_scoreboard board;

   scaled_tanh_silu_gate_cell DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_result(rsp_item);
   end

   task automatic send_item(req_type it);
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(it);
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 16384)) - 8192);
         3: return 16'($signed($urandom_range(0, 4096)) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      req_type it;
      int wait_cnt;
      logic [15:0] corner[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h1000, 16'hF000};
      board = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 5; i++) begin
         it = '{corner[i], corner[i], corner[i], corner[i], corner[i]};
         send_item(it);
      end
      send_item('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000});
      send_item('{16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000});
      send_item('{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF});
      send_item('{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7F00});
      send_item('{16'h5000, 16'h0000, 16'h0000, 16'h0000, 16'h7FF0});
      send_item('{16'h4FFF, 16'h0000, 16'h0000, 16'h0000, 16'h7FF0});
      send_item('{16'h0000, 16'h0001, 16'h0800, 16'h0000, 16'h0001});
      send_item('{16'h0000, 16'hFFFF, 16'h0800, 16'h0000, 16'hFFFF});
      send_item('{16'h0001, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000});
      send_item('{16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF});

      start <= 1'b0;
      wait_cnt = 0;
      while (board.pending.size() != 0 && wait_cnt < 10000) begin
         @(posedge clock);
         wait_cnt++;
      end

      for (int i = 0; i < 1450; i++) begin
         it.input_term = rand_val();
         it.recurrent_term = rand_val();
         it.radius = rand_val();
         it.bias = rand_val();
         it.gate_in = rand_val();
         send_item(it);
         if ($urandom_range(0, 2) == 0) idle_gap();
      end
      start <= 1'b0;

      wait_cnt = 0;
      while (board.pending.size() != 0 && wait_cnt < 10000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
